// ===== src/stereo_flanger_macros.svh =====
// Assertion helpers for the flanger; clk and rst_n are taken from the using scope.
`ifndef STEREO_FLANGER_MACROS_SVH
`define STEREO_FLANGER_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define SFL_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define SFL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/sfl_pkg.sv =====
`timescale 1ns / 1ps

package sfl_pkg;

    // Fixed geometry of the delay store and sine table
    localparam int DELAY_DEPTH = 2048;
    localparam int CHANNELS    = 2;
    localparam int SINE_SIZE   = 256;
    localparam int QUARTER     = SINE_SIZE / 4;
    localparam int PTR_W       = $clog2(DELAY_DEPTH);
    localparam int CH_W        = $clog2(CHANNELS);
    localparam int ADDR_W      = PTR_W + CH_W;
    localparam int STORE_DEPTH = DELAY_DEPTH * CHANNELS;
    localparam int STORE_W     = 18;
    localparam int ROM_IDX_W   = $clog2(QUARTER + 1);

    // Register limits and gains
    localparam logic [18:0]        BASE_MAX   = 19'd524032;
    localparam logic [18:0]        DELAY_MAX  = 19'((DELAY_DEPTH - 1) * 256);
    localparam logic [15:0]        DEPTH_MAX  = 16'd32768;
    localparam logic signed [15:0] FB_MAX     = 16'sd31130;
    localparam logic signed [15:0] FB_MIN     = -16'sd31130;
    localparam logic [15:0]        GAIN_0707  = 16'd23167;
    localparam logic [15:0]        STEP_RST   = 16'd175;
    localparam logic [18:0]        BASE_RST   = 19'd36864;
    localparam logic [15:0]        DEPTH_RST  = 16'd22938;
    localparam logic signed [15:0] FB_RST     = 16'sd9830;

    typedef enum logic [1:0] {
        REG_LFO_STEP   = 2'd0,
        REG_BASE_DELAY = 2'd1,
        REG_DEPTH      = 2'd2,
        REG_FEEDBACK   = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [15:0]        lfo_step;
        logic [18:0]        base_delay;
        logic [15:0]        depth;
        logic signed [15:0] feedback;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_LFO, ST_MUL1, ST_MUL2, ST_DLY, ST_RDA, ST_RDB,
        ST_INTERP, ST_DIFF, ST_MFB, ST_MY, ST_WR, ST_OUT
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE, OP_CLEAR, OP_ACCEPT, OP_LFO, OP_MUL1, OP_MUL2, OP_DLY, OP_RDA,
        OP_RDB, OP_INTERP, OP_DIFF, OP_MFB, OP_MY, OP_WR
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   load_out;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
    } status_t;

    typedef logic [15:0] sine_rom_t [0:QUARTER];

    // Quarter sine, Taylor series in Q30, evaluated at elaboration
    function automatic sine_rom_t build_sine_rom();
        sine_rom_t   rom;
        logic [63:0] x;
        logic [63:0] t;
        logic [63:0] sum;
        for (int k = 0; k <= QUARTER; k++) begin
            x   = (64'd1686629713 * 64'(k)) / 64'(QUARTER);
            t   = x;
            sum = x;
            for (int n = 1; n <= 7; n++) begin
                t = (((t * x) >> 30) * x) >> 30;
                t = t / 64'((2 * n) * (2 * n + 1));
                if ((n % 2) == 1)
                    sum = (sum > t) ? sum - t : 64'd0;
                else
                    sum = sum + t;
            end
            sum = (sum + 64'd16384) >> 15;
            rom[k] = (sum > 64'd32768) ? 16'd32768 : sum[15:0];
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

// ===== src/stereo_flanger.sv =====
`timescale 1ns / 1ps
// Channel  Handshake             Payload
// in       in_valid / in_stall   sample_in, channel
// out      out_valid / out_stall sample_out
// cfg      cfg_valid / cfg_ready cfg_index, cfg_data
//
// Each item steps through the states LFO to OUT in turn before its output word is
// loaded, and no new word is taken until the block is back in IDLE; the shared 32x32
// multiplier runs five products in sequence and the store is read twice through its
// single read port. After reset a clearing pass writes all 4096 store entries, one
// per cycle, with in_stall high; configuration writes are taken at any time. A new
// item is accepted while the previous result still waits under out_stall; the block
// holds only when the next result finds the output full.

module stereo_flanger
    import sfl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] sample_in,
    input  logic               channel,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] sample_out,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    `include "stereo_flanger_macros.svh"

    cfg_t    cfg;
    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    sfl_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cfg_valid && cfg_ready),
        .wr_index(cfg_index),
        .wr_data (cfg_data),
        .cfg     (cfg)
    );

    sfl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .out_stall(out_stall),
        .status   (status),
        .cmd      (cmd),
        .in_stall (in_stall),
        .out_valid(out_valid)
    );

    sfl_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg       (cfg),
        .sample_in (sample_in),
        .channel   (channel),
        .status    (status),
        .sample_out(sample_out)
    );

    // Busy right after taking a word
    `SFL_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accept not followed by busy")
    // A new output word comes only from an item in progress
    `SFL_ASSERT_IMP(a_out_from_item, $rose(out_valid), $past(in_stall), "output word without item")
    // A result is loaded only while busy
    `SFL_ASSERT_IMP(a_load_when_busy, cmd.load_out, in_stall, "result loaded while idle")

endmodule

// ===== src/sfl_ram.sv =====
`timescale 1ns / 1ps

module sfl_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    // Write one entry, register the read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== src/sfl_regs.sv =====
`timescale 1ns / 1ps

module sfl_regs
    import sfl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  logic [1:0]  wr_index,
    input  logic [31:0] wr_data,
    output cfg_t        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Clamp each write to its legal range
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx_t'(wr_index))
                REG_LFO_STEP:
                begin
                    cfg_next.lfo_step = (wr_data[15:0] == 16'd0) ? 16'd1 : wr_data[15:0];
                end
                REG_BASE_DELAY:
                begin
                    cfg_next.base_delay = (wr_data[18:0] > BASE_MAX) ? BASE_MAX
                                                                     : wr_data[18:0];
                end
                REG_DEPTH:
                begin
                    cfg_next.depth = (wr_data[15:0] > DEPTH_MAX) ? DEPTH_MAX : wr_data[15:0];
                end
                REG_FEEDBACK:
                begin
                    if ($signed(wr_data[15:0]) > FB_MAX)
                        cfg_next.feedback = FB_MAX;
                    else if ($signed(wr_data[15:0]) < FB_MIN)
                        cfg_next.feedback = FB_MIN;
                    else
                        cfg_next.feedback = $signed(wr_data[15:0]);
                end
                default:
                begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lfo_step   <= STEP_RST;
            cfg_reg.base_delay <= BASE_RST;
            cfg_reg.depth      <= DEPTH_RST;
            cfg_reg.feedback   <= FB_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/sfl_ctrl.sv =====
`timescale 1ns / 1ps

module sfl_ctrl
    import sfl_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  logic    out_stall,
    input  status_t status,
    output cmd_t    cmd,
    output logic    in_stall,
    output logic    out_valid
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    // Next state and datapath command
    always_comb
    begin
        state_next   = state_reg;
        cmd.op       = OP_NONE;
        cmd.load_out = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.op = OP_CLEAR;
                if (status.clear_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_ACCEPT;
                    state_next = ST_LFO;
                end
            end
            ST_LFO:    begin cmd.op = OP_LFO;    state_next = ST_MUL1;   end
            ST_MUL1:   begin cmd.op = OP_MUL1;   state_next = ST_MUL2;   end
            ST_MUL2:   begin cmd.op = OP_MUL2;   state_next = ST_DLY;    end
            ST_DLY:    begin cmd.op = OP_DLY;    state_next = ST_RDA;    end
            ST_RDA:    begin cmd.op = OP_RDA;    state_next = ST_RDB;    end
            ST_RDB:    begin cmd.op = OP_RDB;    state_next = ST_INTERP; end
            ST_INTERP: begin cmd.op = OP_INTERP; state_next = ST_DIFF;   end
            ST_DIFF:   begin cmd.op = OP_DIFF;   state_next = ST_MFB;    end
            ST_MFB:    begin cmd.op = OP_MFB;    state_next = ST_MY;     end
            ST_MY:     begin cmd.op = OP_MY;     state_next = ST_WR;     end
            ST_WR:     begin cmd.op = OP_WR;     state_next = ST_OUT;    end
            ST_OUT:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Track the output word
    always_comb
    begin
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== src/sfl_dp.sv =====
`timescale 1ns / 1ps

module sfl_dp
    import sfl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    input  cfg_t               cfg,
    input  logic signed [15:0] sample_in,
    input  logic               channel,
    output status_t            status,
    output logic signed [15:0] sample_out
);

    // Item registers
    logic signed [15:0]  x_reg;
    logic [CH_W-1:0]     ch_reg;
    logic [15:0]         smag_reg;
    logic                sneg_reg;
    logic [PTR_W-1:0]    ri_reg;
    logic [7:0]          frac_reg;
    logic [STORE_W-1:0]  a_reg;
    logic signed [18:0]  d_reg;
    logic [STORE_W-1:0]  nv_reg;
    logic signed [63:0]  prod_reg;
    logic signed [15:0]  sample_out_reg;

    // Per-channel state and clear sweep
    logic [23:0]         phase_reg [0:CHANNELS-1];
    logic [PTR_W-1:0]    wp_reg [0:CHANNELS-1];
    logic [ADDR_W-1:0]   clr_cnt_reg;

    // Shared multiplier
    logic signed [31:0]  mul_a;
    logic signed [31:0]  mul_b;

    // Memory port
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [STORE_W-1:0]  ram_wdata;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [STORE_W-1:0]  ram_rdata;

    // Combinational terms
    logic [23:0]         phase_new;
    logic [7:0]          sin_idx;
    logic [ROM_IDX_W-1:0] rom_idx;
    logic [18:0]         mag;
    logic signed [20:0]  dly_sum;
    logic [18:0]         dly;
    logic [18:0]         pos;
    logic signed [18:0]  diff;
    logic signed [27:0]  interp_sum;
    logic signed [19:0]  d_full;
    logic signed [35:0]  fb_sum;
    logic signed [21:0]  nv_full;
    logic signed [19:0]  xd;
    logic signed [36:0]  y_sum;
    logic signed [21:0]  y_full;
    logic [PTR_W-1:0]    wp_cur;

    assign wp_cur = wp_reg[ch_reg];

    // Advance phase and look up the quarter-wave table
    assign phase_new = phase_reg[ch_reg] + {8'd0, cfg.lfo_step};
    assign sin_idx   = phase_new[23:16];
    assign rom_idx   = sin_idx[6] ? (ROM_IDX_W'(QUARTER) - {1'b0, sin_idx[5:0]})
                                  : {1'b0, sin_idx[5:0]};

    // Swept delay, clamped, then read position
    assign mag     = prod_reg[48:30];
    assign dly_sum = sneg_reg ? ($signed({2'b00, cfg.base_delay}) - $signed({2'b00, mag}))
                              : ($signed({2'b00, cfg.base_delay}) + $signed({2'b00, mag}));
    always_comb
    begin
        if (dly_sum < 0)
            dly = 19'd0;
        else if (dly_sum > $signed({2'b00, DELAY_MAX}))
            dly = DELAY_MAX;
        else
            dly = dly_sum[18:0];
    end
    assign pos = {wp_cur, 8'd0} - dly;

    // Interpolate and apply gains
    assign diff       = $signed({ram_rdata[STORE_W-1], ram_rdata}) -
                        $signed({a_reg[STORE_W-1], a_reg});
    assign interp_sum = prod_reg[27:0] + 28'sd128;
    assign d_full     = $signed({{2{a_reg[STORE_W-1]}}, a_reg}) + interp_sum[27:8];
    assign fb_sum     = prod_reg[35:0] + 36'sd16384;
    assign nv_full    = 22'(x_reg) + 22'($signed(fb_sum[35:15]));
    assign xd         = 20'(x_reg) + 20'(d_reg);
    assign y_sum      = prod_reg[36:0] + 37'sd16384;
    assign y_full     = y_sum[36:15];

    // Pick multiplier operands
    always_comb
    begin
        mul_a = 32'sd0;
        mul_b = 32'sd0;
        case (cmd.op)
            OP_MUL1:
            begin
                mul_a = $signed({16'd0, cfg.depth});
                mul_b = $signed({16'd0, smag_reg});
            end
            OP_MUL2:
            begin
                mul_a = $signed({1'b0, prod_reg[30:0]});
                mul_b = $signed({13'd0, cfg.base_delay});
            end
            OP_INTERP:
            begin
                mul_a = 32'(diff);
                mul_b = $signed({24'd0, frac_reg});
            end
            OP_MFB:
            begin
                mul_a = 32'(d_reg);
                mul_b = 32'(cfg.feedback);
            end
            OP_MY:
            begin
                mul_a = 32'(xd);
                mul_b = $signed({16'd0, GAIN_0707});
            end
            default:
            begin
                mul_a = 32'sd0;
                mul_b = 32'sd0;
            end
        endcase
    end

    // Memory addressing
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = {ch_reg, wp_cur};
        ram_wdata = nv_reg;
        ram_raddr = {ch_reg, ri_reg};
        case (cmd.op)
            OP_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = '0;
            end
            OP_RDB:
            begin
                ram_raddr = {ch_reg, ri_reg + 1'b1};
            end
            OP_WR:
            begin
                ram_we = 1'b1;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    sfl_ram #(
        .WIDTH(STORE_W),
        .DEPTH(STORE_DEPTH)
    ) u_store (
        .clk    (clk),
        .wr_en  (ram_we),
        .wr_addr(ram_waddr),
        .wr_data(ram_wdata),
        .rd_addr(ram_raddr),
        .rd_data(ram_rdata)
    );

    // Control state: phases, pointers, clear sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                phase_reg[c] <= 24'd0;
                wp_reg[c]    <= '0;
            end
            clr_cnt_reg <= '0;
        end
        else
        begin
            if (cmd.op == OP_CLEAR)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (cmd.op == OP_LFO)
                phase_reg[ch_reg] <= phase_new;
            if (cmd.op == OP_WR)
                wp_reg[ch_reg] <= wp_cur + 1'b1;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_ACCEPT:
            begin
                x_reg  <= sample_in;
                ch_reg <= channel;
            end
            OP_LFO:
            begin
                smag_reg <= SINE_ROM[rom_idx];
                sneg_reg <= sin_idx[7];
            end
            OP_DLY:
            begin
                ri_reg   <= pos[18:8];
                frac_reg <= pos[7:0];
            end
            OP_RDB:
            begin
                a_reg <= ram_rdata;
            end
            OP_DIFF:
            begin
                d_reg <= d_full[18:0];
            end
            OP_MY:
            begin
                if (nv_full > 22'sd131071)
                    nv_reg <= 18'h1FFFF;
                else if (nv_full < -22'sd131072)
                    nv_reg <= 18'h20000;
                else
                    nv_reg <= nv_full[17:0];
            end
            default:
            begin
            end
        endcase

        if (cmd.op == OP_MUL1 || cmd.op == OP_MUL2 || cmd.op == OP_INTERP ||
            cmd.op == OP_MFB || cmd.op == OP_MY)
            prod_reg <= mul_a * mul_b;

        // Saturate the result into the output word
        if (cmd.load_out)
        begin
            if (y_full > 22'sd32767)
                sample_out_reg <= 16'sh7FFF;
            else if (y_full < -22'sd32768)
                sample_out_reg <= -16'sh8000;
            else
                sample_out_reg <= y_full[15:0];
        end
    end

    assign status.clear_last = (clr_cnt_reg == {ADDR_W{1'b1}});
    assign sample_out        = sample_out_reg;

endmodule

// ===== sim/stereo_flanger_checker.sv =====
`timescale 1ns / 1ps

module stereo_flanger_checker
    import sfl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic signed [15:0] sample_in,
    input  logic               channel,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [15:0] sample_out,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output int                 errors,
    output int                 pending
);

    // Local copy of the flanger state
    logic [15:0]        step_r;
    logic [18:0]        base_r;
    logic [15:0]        depth_r;
    logic signed [15:0] fb_r;
    logic [17:0]        delay_mem [0:STORE_DEPTH-1];
    logic [10:0]        wptr [0:1];
    logic [23:0]        phase [0:1];
    logic [15:0]        quarter_sine [0:QUARTER];
    logic signed [15:0] out_fifo [$];

    // Floor division by 2^n of a signed value
    function automatic longint floor_div(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // Quarter-wave sine, computed here independently
    function automatic logic [15:0] sine_point(int k);
        longint unsigned x, t, acc;
        x   = 64'd1686629713 * k / QUARTER;
        t   = x;
        acc = x;
        for (int n = 1; n <= 7; n++)
        begin
            t = ((t * x) >> 30) * x >> 30;
            t = t / ((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
                acc = acc > t ? acc - t : 0;
            else
                acc = acc + t;
        end
        acc = (acc + 16384) >> 15;
        return acc > 32768 ? 16'd32768 : acc[15:0];
    endfunction

    // Work out one flanged word and update the delay line
    function automatic logic signed [15:0] flange_sample(logic signed [15:0] x, logic ch);
        longint unsigned idx, pos, mag;
        longint s, dly, a, b, d, nv, y;
        int quad, off, ri, ni, frac, base_addr;
        logic [10:0] wp;
        wp = wptr[ch];
        base_addr = ch * DELAY_DEPTH;
        phase[ch] = phase[ch] + 24'(step_r);
        idx  = (longint'(phase[ch]) * SINE_SIZE) >> 24;
        quad = int'((idx / QUARTER) % 4);
        off  = int'(idx % QUARTER);
        s = quad[0] ? quarter_sine[QUARTER - off] : quarter_sine[off];
        if (quad[1])
            s = -s;
        mag = (longint'(base_r) * depth_r * (s < 0 ? -s : s)) >> 30;
        dly = s < 0 ? longint'(base_r) - longint'(mag) : longint'(base_r) + longint'(mag);
        dly = clip(dly, 0, (DELAY_DEPTH - 1) * 256);
        pos  = (longint'(wp) * 256 + DELAY_DEPTH * 256 - dly) % (DELAY_DEPTH * 256);
        ri   = int'(pos >> 8);
        frac = int'(pos & 255);
        ni   = (ri + 1) % DELAY_DEPTH;
        a = longint'($signed(delay_mem[base_addr + ri]));
        b = longint'($signed(delay_mem[base_addr + ni]));
        d = a + floor_div((b - a) * frac + 128, 8);
        nv = clip(x + floor_div(d * fb_r + 16384, 15), -131072, 131071);
        delay_mem[base_addr + wp] = nv[17:0];
        wptr[ch] = wp + 11'd1;
        y = clip(floor_div((x + d) * 23167 + 16384, 15), -32768, 32767);
        return y[15:0];
    endfunction

    initial
    begin
        for (int k = 0; k <= QUARTER; k++)
            quarter_sine[k] = sine_point(k);
    end

    always @(posedge clk or negedge rst_n)
    begin
        logic signed [15:0] want;
        logic [15:0]        v16;
        logic [18:0]        v19;
        logic signed [15:0] sv;
        if (!rst_n)
        begin
            step_r  = 16'd175;
            base_r  = 19'd36864;
            depth_r = 16'd22938;
            fb_r    = 16'sd9830;
            for (int k = 0; k < STORE_DEPTH; k++)
                delay_mem[k] = '0;
            wptr[0] = '0;
            wptr[1] = '0;
            phase[0] = '0;
            phase[1] = '0;
            out_fifo.delete();
            errors  = 0;
            pending = 0;
        end
        else
        begin
            // Mirror register writes, clamped as the block does
            if (cfg_valid && cfg_ready)
            begin
                case (reg_idx_t'(cfg_index))
                    REG_LFO_STEP:
                    begin
                        v16 = cfg_data[15:0];
                        step_r = (v16 == 0) ? 16'd1 : v16;
                    end
                    REG_BASE_DELAY:
                    begin
                        v19 = cfg_data[18:0];
                        base_r = (v19 > 19'd524032) ? 19'd524032 : v19;
                    end
                    REG_DEPTH:
                    begin
                        v16 = cfg_data[15:0];
                        depth_r = (v16 > 16'd32768) ? 16'd32768 : v16;
                    end
                    REG_FEEDBACK:
                    begin
                        sv = cfg_data[15:0];
                        fb_r = (sv > 16'sd31130) ? 16'sd31130 :
                               (sv < -16'sd31130) ? -16'sd31130 : sv;
                    end
                    default: ;
                endcase
            end
            // Predict each accepted word
            if (in_valid && !in_stall)
                out_fifo.push_back(flange_sample(sample_in, channel));
            // Compare each delivered word
            if (out_valid && !out_stall)
            begin
                if (out_fifo.size() == 0)
                begin
                    $display("%0t: unexpected word: expected none, actual %0d",
                             $time, sample_out);
                    errors++;
                end
                else
                begin
                    want = out_fifo.pop_front();
                    if (want !== sample_out)
                    begin
                        $display("%0t: sample_out mismatch: expected %0d, actual %0d",
                                 $time, want, sample_out);
                        errors++;
                    end
                end
            end
            pending = out_fifo.size();
        end
    end

endmodule

// ===== sim/stereo_flanger_tb.sv =====
`timescale 1ns / 1ps

module stereo_flanger_tb;
    import sfl_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic signed [15:0] sample_in;
    logic               channel;
    logic               out_valid;
    logic               out_stall;
    logic signed [15:0] sample_out;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [31:0]        cfg_data;
    int                 errors;
    int                 pending;
    bit                 drain_free;
    int                 stall_left;

    stereo_flanger u_top (.*);

    stereo_flanger_checker u_chk (.*);

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic idle_cycles(int n);
        repeat (n) @(negedge clk);
    endtask

    // Write one register, idle block only
    task automatic write_reg(reg_idx_t idx, logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Present one word and hold it until taken; valid stays up for the next word
    task automatic send_word(logic signed [15:0] value, logic ch, bit no_gap);
        int n;
        n = no_gap ? 0 : gap_len();
        if (n != 0)
        begin
            in_valid <= 1'b0;
            idle_cycles(n);
        end
        in_valid  <= 1'b1;
        sample_in <= value;
        channel   <= ch;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        idle_cycles(40);
    endtask

    task automatic random_burst(int count);
        bit burst;
        for (int i = 0; i < count; i++)
        begin
            burst = (i / 100) % 3 == 0;
            send_word(16'($urandom()), 1'($urandom_range(0, 1)), burst);
        end
    endtask

    // Random stall runs on the result side
    always @(negedge clk)
    begin
        if (!rst_n || drain_free)
        begin
            stall_left = 0;
            out_stall <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            stall_left = stall_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            stall_left = gap_len();
            out_stall <= (stall_left != 0);
            if (stall_left != 0)
                stall_left = stall_left - 1;
        end
    end

    initial
    begin
        logic signed [15:0] edge_vals [8];
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        sample_in  = '0;
        channel    = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = REG_LFO_STEP;
        cfg_data   = '0;
        drain_free = 1'b0;
        edge_vals = '{16'sh7fff, -16'sh8000, 16'sh0000, -16'sh0001,
                      16'sh7fff, 16'sh7fff, -16'sh8000, 16'sh5555};
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: extremes at reset settings
        foreach (edge_vals[i])
            send_word(edge_vals[i], 1'(i % 2), 1'b0);
        wait_drained();

        // Zero delay, full feedback
        write_reg(REG_BASE_DELAY, 32'd0);
        write_reg(REG_FEEDBACK, 32'd31130);
        write_reg(REG_LFO_STEP, 32'd0);
        for (int i = 0; i < 8; i++)
            send_word(16'sh7fff, 1'b0, 1'b0);
        wait_drained();

        // Longest delay, full depth, out-of-range writes clamp
        write_reg(REG_BASE_DELAY, 32'h0007ffff);
        write_reg(REG_DEPTH, 32'h0000ffff);
        write_reg(REG_FEEDBACK, 32'h00008000);
        write_reg(REG_LFO_STEP, 32'd65535);
        for (int i = 0; i < 8; i++)
            send_word(-16'sh8000, 1'(i % 2), 1'b0);
        wait_drained();

        // Random phases, each with its own settings
        for (int p = 0; p < 11; p++)
        begin
            write_reg(REG_LFO_STEP, $urandom());
            write_reg(REG_BASE_DELAY, p == 0 ? 32'd524032 : $urandom_range(0, 600000));
            write_reg(REG_DEPTH, p == 1 ? 32'd0 : $urandom_range(0, 40000));
            write_reg(REG_FEEDBACK, p == 2 ? 32'hffff8666 : $urandom());
            random_burst(150);
            wait_drained();
        end

        drain_free = 1'b1;
        wait_drained();
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #60ms;
        $display("FAILURE");
        $finish;
    end

endmodule
